### rtl/core/lkvc_pkg.sv
`timescale 1ns / 1ps

package lkvc_pkg;

    localparam int MAX_ENTRIES_DEFAULT = 16;
    localparam int KEY_BITS_DEFAULT    = 32;
    localparam int VALUE_BITS_DEFAULT  = 32;
    localparam int COUNT_BITS_DEFAULT  = 16;
    localparam int STAMP_BITS          = 32;
    localparam int LIMIT_BITS          = 5;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd16;
    localparam logic [31:0]           MISS_VALUE  = 32'hFFFF_FFFF;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] lookup_key;
        logic signed [31:0] write_value;
    } request_t;

    typedef struct packed {
        logic               found;
        logic signed [31:0] read_value;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic read_en;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_get;
        logic out_busy;
    } dp_status_t;

endpackage

### rtl/core/lfu_key_value_cache.sv
`timescale 1ns / 1ps

// Key-value cache with least-frequently-used replacement and oldest-stamp tie break.
// Every get returns one result transfer (found and the value, or -1 on a miss); a put
// returns nothing and is dropped while the entry limit is zero. Each item goes from
// acceptance to the next acceptance through an accept state, a scan state per slot as
// the single read port of the entry memory is swept for the key, a free slot and the
// victim, a drain state for the last compare and a commit state for the writeback. A
// finished result waits in the output register; the next request is still accepted and
// swept, but a get holds its writeback until that register is free.
// The entry limit may be written only while the cache is idle.
module lfu_key_value_cache #(
    parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEFAULT,
    parameter int KEY_BITS    = lkvc_pkg::KEY_BITS_DEFAULT,
    parameter int VALUE_BITS  = lkvc_pkg::VALUE_BITS_DEFAULT,
    parameter int COUNT_BITS  = lkvc_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              request_valid,
    output logic                              request_stall,
    input  lkvc_pkg::request_t                request_item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output lkvc_pkg::result_t                 result_item,
    input  logic                              limit_write_en,
    input  logic [lkvc_pkg::LIMIT_BITS-1:0]   limit_data
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    lkvc_pkg::ctrl_cmd_t  cmd;
    lkvc_pkg::dp_status_t status;
    logic [IDX_W-1:0]     scan_addr;

    lkvc_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_stall (request_stall),
        .status        (status),
        .cmd           (cmd),
        .scan_addr     (scan_addr)
    );

    lkvc_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS),
        .VALUE_BITS  (VALUE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .request_item   (request_item),
        .result_item    (result_item),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .limit_write_en (limit_write_en),
        .limit_data     (limit_data),
        .cmd            (cmd),
        .scan_addr      (scan_addr),
        .status         (status)
    );

endmodule

### rtl/core/lkvc_ctrl.sv
`timescale 1ns / 1ps

module lkvc_ctrl #(
    parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEFAULT,
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   request_valid,
    output logic                   request_stall,
    input  lkvc_pkg::dp_status_t   status,
    output lkvc_pkg::ctrl_cmd_t    cmd,
    output logic [IDX_W-1:0]       scan_addr
);

    lkvc_pkg::state_t state_reg;
    lkvc_pkg::state_t state_next;
    logic [IDX_W-1:0] scan_idx_reg;
    logic [IDX_W-1:0] scan_idx_next;
    logic             scan_last;
    logic             commit_ok;

    assign scan_last = (scan_idx_reg == IDX_W'(MAX_ENTRIES - 1));
    assign commit_ok = !(status.is_get && status.out_busy);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lkvc_pkg::ST_IDLE:
            begin
                if (request_valid)
                begin
                    state_next = lkvc_pkg::ST_SCAN;
                end
            end
            lkvc_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = lkvc_pkg::ST_DRAIN;
                end
            end
            lkvc_pkg::ST_DRAIN:
            begin
                state_next = lkvc_pkg::ST_COMMIT;
            end
            lkvc_pkg::ST_COMMIT:
            begin
                if (commit_ok)
                begin
                    state_next = lkvc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lkvc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (state_reg == lkvc_pkg::ST_SCAN && !scan_last)
        begin
            scan_idx_next = scan_idx_reg + IDX_W'(1);
        end
        else
        begin
            scan_idx_next = '0;
        end
    end

    always_comb
    begin
        cmd           = '0;
        request_stall = 1'b1;
        scan_addr     = scan_idx_reg;
        case (state_reg)
            lkvc_pkg::ST_IDLE:
            begin
                request_stall = 1'b0;
                cmd.capture   = request_valid;
            end
            lkvc_pkg::ST_SCAN:
            begin
                cmd.read_en = 1'b1;
            end
            lkvc_pkg::ST_DRAIN:
            begin
                cmd = '0;
            end
            lkvc_pkg::ST_COMMIT:
            begin
                cmd.commit = commit_ok;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lkvc_pkg::ST_IDLE;
            scan_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
        end
    end

endmodule

### rtl/core/lkvc_datapath.sv
`timescale 1ns / 1ps

module lkvc_datapath #(
    parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEFAULT,
    parameter int KEY_BITS    = lkvc_pkg::KEY_BITS_DEFAULT,
    parameter int VALUE_BITS  = lkvc_pkg::VALUE_BITS_DEFAULT,
    parameter int COUNT_BITS  = lkvc_pkg::COUNT_BITS_DEFAULT,
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lkvc_pkg::request_t                request_item,
    output lkvc_pkg::result_t                 result_item,
    output logic                              result_valid,
    input  logic                              result_stall,
    input  logic                              limit_write_en,
    input  logic [lkvc_pkg::LIMIT_BITS-1:0]   limit_data,
    input  lkvc_pkg::ctrl_cmd_t               cmd,
    input  logic [IDX_W-1:0]                  scan_addr,
    output lkvc_pkg::dp_status_t              status
);

    localparam int SB      = lkvc_pkg::STAMP_BITS;
    localparam int ENTRY_W = KEY_BITS + VALUE_BITS + COUNT_BITS + SB;
    localparam int OCC_W   = $clog2(MAX_ENTRIES + 1);
    localparam int LIM_W   = (OCC_W > lkvc_pkg::LIMIT_BITS) ? OCC_W : lkvc_pkg::LIMIT_BITS;
    localparam int CNT_LO  = SB;
    localparam int VAL_LO  = SB + COUNT_BITS;
    localparam int KEY_LO  = SB + COUNT_BITS + VALUE_BITS;

    logic [ENTRY_W-1:0] mem [MAX_ENTRIES];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               eval_en_reg;

    logic                  req_kind_reg;
    logic [KEY_BITS-1:0]   req_key_reg;
    logic [VALUE_BITS-1:0] req_value_reg;
    logic [63:0]           key_wide;
    logic [63:0]           value_wide;

    logic [MAX_ENTRIES-1:0]            valid_reg;
    logic [OCC_W-1:0]                  occ_reg;
    logic [SB-1:0]                     touch_reg;
    logic [lkvc_pkg::LIMIT_BITS-1:0]   limit_reg;

    logic                  hit_found_reg;
    logic [IDX_W-1:0]      hit_idx_reg;
    logic [VALUE_BITS-1:0] hit_value_reg;
    logic [COUNT_BITS-1:0] hit_count_reg;
    logic                  free_found_reg;
    logic [IDX_W-1:0]      free_idx_reg;
    logic                  victim_found_reg;
    logic [IDX_W-1:0]      victim_idx_reg;
    logic [COUNT_BITS-1:0] best_count_reg;
    logic [SB-1:0]         best_stamp_reg;

    logic                  out_valid_reg;
    lkvc_pkg::result_t     out_item_reg;

    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_value;
    logic [COUNT_BITS-1:0] rd_count;
    logic [SB-1:0]         rd_stamp;
    logic                  rd_slot_valid;
    logic                  rd_better;

    logic [LIM_W-1:0]      limit_eff;
    logic                  is_get;
    logic                  put_enabled;
    logic                  use_free;
    logic [COUNT_BITS-1:0] hit_count_inc;
    logic [SB-1:0]         touch_inc;
    logic                  mem_we;
    logic [IDX_W-1:0]      wr_idx;
    logic [ENTRY_W-1:0]    wr_entry;
    logic [VALUE_BITS+31:0] hit_value_ext;

    assign key_wide   = {{32{request_item.lookup_key[31]}}, request_item.lookup_key};
    assign value_wide = {{32{request_item.write_value[31]}}, request_item.write_value};

    assign rd_key        = rd_data_reg[KEY_LO +: KEY_BITS];
    assign rd_value      = rd_data_reg[VAL_LO +: VALUE_BITS];
    assign rd_count      = rd_data_reg[CNT_LO +: COUNT_BITS];
    assign rd_stamp      = rd_data_reg[SB-1:0];
    assign rd_slot_valid = valid_reg[rd_idx_reg];
    assign rd_better     = !victim_found_reg || (rd_count < best_count_reg)
                           || ((rd_count == best_count_reg) && (rd_stamp < best_stamp_reg));

    assign limit_eff = (LIM_W'(limit_reg) > LIM_W'(MAX_ENTRIES)) ? LIM_W'(MAX_ENTRIES)
                                                                  : LIM_W'(limit_reg);
    assign is_get      = (req_kind_reg == lkvc_pkg::KIND_GET);
    assign put_enabled = (limit_eff != '0);
    assign use_free    = (LIM_W'(occ_reg) < limit_eff) && free_found_reg;

    assign hit_count_inc = (hit_count_reg == '1) ? hit_count_reg : hit_count_reg + COUNT_BITS'(1);
    assign touch_inc     = (touch_reg == '1) ? touch_reg : touch_reg + SB'(1);
    assign hit_value_ext = {{32{hit_value_reg[VALUE_BITS-1]}}, hit_value_reg};

    always_comb
    begin
        mem_we   = 1'b0;
        wr_idx   = hit_idx_reg;
        wr_entry = {req_key_reg, req_value_reg, hit_count_inc, touch_reg};
        if (cmd.commit)
        begin
            if (is_get)
            begin
                mem_we   = hit_found_reg;
                wr_entry = {req_key_reg, hit_value_reg, hit_count_inc, touch_reg};
            end
            else if (put_enabled)
            begin
                mem_we = 1'b1;
                if (!hit_found_reg)
                begin
                    wr_idx   = use_free ? free_idx_reg : victim_idx_reg;
                    wr_entry = {req_key_reg, req_value_reg, COUNT_BITS'(1), touch_reg};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_idx] <= wr_entry;
        end
        if (cmd.read_en)
        begin
            rd_data_reg <= mem[scan_addr];
            rd_idx_reg  <= scan_addr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_kind_reg  <= request_item.kind;
            req_key_reg   <= key_wide[KEY_BITS-1:0];
            req_value_reg <= value_wide[VALUE_BITS-1:0];
        end
        if (eval_en_reg)
        begin
            if (rd_slot_valid && (rd_key == req_key_reg) && !hit_found_reg)
            begin
                hit_idx_reg   <= rd_idx_reg;
                hit_value_reg <= rd_value;
                hit_count_reg <= rd_count;
            end
            if (!rd_slot_valid && !free_found_reg)
            begin
                free_idx_reg <= rd_idx_reg;
            end
            if (rd_slot_valid && rd_better)
            begin
                victim_idx_reg <= rd_idx_reg;
                best_count_reg <= rd_count;
                best_stamp_reg <= rd_stamp;
            end
        end
        if (cmd.commit && is_get)
        begin
            out_item_reg.found      <= hit_found_reg;
            out_item_reg.read_value <= hit_found_reg ? hit_value_ext[31:0] : lkvc_pkg::MISS_VALUE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eval_en_reg      <= 1'b0;
            hit_found_reg    <= 1'b0;
            free_found_reg   <= 1'b0;
            victim_found_reg <= 1'b0;
            valid_reg        <= '0;
            occ_reg          <= '0;
            touch_reg        <= '0;
            limit_reg        <= lkvc_pkg::LIMIT_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            eval_en_reg <= cmd.read_en;
            if (limit_write_en)
            begin
                limit_reg <= limit_data;
            end
            if (cmd.capture)
            begin
                hit_found_reg    <= 1'b0;
                free_found_reg   <= 1'b0;
                victim_found_reg <= 1'b0;
            end
            else if (eval_en_reg)
            begin
                if (rd_slot_valid && (rd_key == req_key_reg))
                begin
                    hit_found_reg <= 1'b1;
                end
                if (!rd_slot_valid)
                begin
                    free_found_reg <= 1'b1;
                end
                if (rd_slot_valid)
                begin
                    victim_found_reg <= 1'b1;
                end
            end
            if (mem_we)
            begin
                touch_reg <= touch_inc;
            end
            if (cmd.commit && !is_get && put_enabled && !hit_found_reg)
            begin
                valid_reg[wr_idx] <= 1'b1;
                if (use_free)
                begin
                    occ_reg <= occ_reg + OCC_W'(1);
                end
            end
            if (cmd.commit && is_get)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid    = out_valid_reg;
    assign result_item     = out_item_reg;
    assign status.is_get   = is_get;
    assign status.out_busy = out_valid_reg && result_stall;

endmodule
